FILE: hw/rtl/rpi_pkg.sv
// ----------------------------------------------------------------------------
// Ray/panel intersection package
// Shared widths, register codes, reset values and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package rpi_pkg;

   localparam int MAX_PANEL_DIM_DEF = 1024;

   localparam int COORD_W    = 16;   // Q7.8 coordinate word
   localparam int EDGE_W     = 17;   // corner or origin difference
   localparam int NORM_W     = 35;   // u x v component
   localparam int GRAM_W     = 36;   // u.u, v.v, u.v
   localparam int PROJ_W     = 54;   // u*uv - v*uu
   localparam int CROSS_W    = 34;   // (P - c0) x d component
   localparam int DEN_DOT_W  = 53;   // n.d
   localparam int WIDE_W     = 92;   // numerators and denominators
   localparam int SPLIT      = 27;   // multiplier operand split point
   localparam int DIM_W      = 11;
   localparam int PIX_W      = 12;
   localparam int CORNER_W   = 48;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // cycles for the corner-derived terms to settle after a register write
   localparam int SETTLE_W = 3;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd6;

   typedef enum logic [2:0] {
      REG_CORNER_ORIGIN = 3'd0,
      REG_CORNER_U_END  = 3'd1,
      REG_CORNER_V_END  = 3'd2,
      REG_PANEL_WIDTH   = 3'd3,
      REG_PANEL_HEIGHT  = 3'd4
   } reg_index_type;

   localparam logic [CORNER_W-1:0] CORNER_ORIGIN_RST = 48'd279275978685440;
   localparam logic [CORNER_W-1:0] CORNER_U_END_RST  = 48'd2199048485888;
   localparam logic [CORNER_W-1:0] CORNER_V_END_RST  = 48'd279276045794304;
   localparam logic [DIM_W-1:0]    PANEL_DIM_RST     = 11'd512;

   localparam logic signed [PIX_W-1:0] MISS_PIXEL = -12'sd99;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] direction_x;
      logic signed [COORD_W-1:0] direction_y;
      logic signed [COORD_W-1:0] direction_z;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
   } rsp_type;

   // terms that depend on the panel corners only
   typedef struct packed {
      logic signed [COORD_W-1:0] c0_x;
      logic signed [COORD_W-1:0] c0_y;
      logic signed [COORD_W-1:0] c0_z;
      logic signed [NORM_W-1:0]  n_x;
      logic signed [NORM_W-1:0]  n_y;
      logic signed [NORM_W-1:0]  n_z;
      logic signed [PROJ_W-1:0]  un_x;
      logic signed [PROJ_W-1:0]  un_y;
      logic signed [PROJ_W-1:0]  un_z;
      logic signed [PROJ_W-1:0]  vn_x;
      logic signed [PROJ_W-1:0]  vn_y;
      logic signed [PROJ_W-1:0]  vn_z;
      logic signed [GRAM_W-1:0]  uu;
      logic signed [GRAM_W-1:0]  vv;
   } derived_type;

   typedef struct packed {
      logic signed [WIDE_W-1:0] num_x;
      logic signed [WIDE_W-1:0] den_x;
      logic signed [WIDE_W-1:0] num_y;
      logic signed [WIDE_W-1:0] den_y;
   } ratio_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rpi_setup.sv
// ----------------------------------------------------------------------------
// Panel setup pipeline
// Derives edges, normal, Gram terms and projection vectors from the corners.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_setup (
   input  wire logic                          clock,
   input  wire logic [rpi_pkg::CORNER_W-1:0]  corner_origin,
   input  wire logic [rpi_pkg::CORNER_W-1:0]  corner_u_end,
   input  wire logic [rpi_pkg::CORNER_W-1:0]  corner_v_end,
   output rpi_pkg::derived_type               derived
);
   import rpi_pkg::*;

   localparam int PROD_W = 2 * EDGE_W;          // 34
   localparam int WP_W   = EDGE_W + GRAM_W;     // 53

   logic signed [COORD_W-1:0] c0_ff [3];
   logic signed [COORD_W-1:0] c0_in [3];
   logic signed [EDGE_W-1:0]  u_ff [3];
   logic signed [EDGE_W-1:0]  u_in [3];
   logic signed [EDGE_W-1:0]  v_ff [3];
   logic signed [EDGE_W-1:0]  v_in [3];
   logic signed [PROD_W-1:0]  pn_ff [6];
   logic signed [PROD_W-1:0]  pn_in [6];
   logic signed [PROD_W-1:0]  puu_ff [3];
   logic signed [PROD_W-1:0]  puu_in [3];
   logic signed [PROD_W-1:0]  pvv_ff [3];
   logic signed [PROD_W-1:0]  pvv_in [3];
   logic signed [PROD_W-1:0]  puv_ff [3];
   logic signed [PROD_W-1:0]  puv_in [3];
   logic signed [NORM_W-1:0]  n_ff [3];
   logic signed [NORM_W-1:0]  n_in [3];
   logic signed [GRAM_W-1:0]  uu_ff, uu_in, vv_ff, vv_in, uv_ff, uv_in;
   logic signed [WP_W-1:0]    pa_ff [3];
   logic signed [WP_W-1:0]    pa_in [3];
   logic signed [WP_W-1:0]    pb_ff [3];
   logic signed [WP_W-1:0]    pb_in [3];
   logic signed [WP_W-1:0]    pc_ff [3];
   logic signed [WP_W-1:0]    pc_in [3];
   logic signed [WP_W-1:0]    pd_ff [3];
   logic signed [WP_W-1:0]    pd_in [3];
   logic signed [PROJ_W-1:0]  un_ff [3];
   logic signed [PROJ_W-1:0]  un_in [3];
   logic signed [PROJ_W-1:0]  vn_ff [3];
   logic signed [PROJ_W-1:0]  vn_in [3];
   logic signed [COORD_W-1:0] c1 [3];
   logic signed [COORD_W-1:0] c3 [3];
   logic signed [COORD_W-1:0] c0 [3];

   always_comb begin
      c0[0] = $signed(corner_origin[47:32]);
      c0[1] = $signed(corner_origin[31:16]);
      c0[2] = $signed(corner_origin[15:0]);
      c1[0] = $signed(corner_u_end[47:32]);
      c1[1] = $signed(corner_u_end[31:16]);
      c1[2] = $signed(corner_u_end[15:0]);
      c3[0] = $signed(corner_v_end[47:32]);
      c3[1] = $signed(corner_v_end[31:16]);
      c3[2] = $signed(corner_v_end[15:0]);
      for (int i = 0; i < 3; i++) begin
         c0_in[i] = c0[i];
         u_in[i]  = EDGE_W'(c1[i]) - EDGE_W'(c0[i]);
         v_in[i]  = EDGE_W'(c3[i]) - EDGE_W'(c0[i]);
      end
   end

   // normal and Gram products
   always_comb begin
      pn_in[0] = PROD_W'(u_ff[1]) * PROD_W'(v_ff[2]);
      pn_in[1] = PROD_W'(u_ff[2]) * PROD_W'(v_ff[1]);
      pn_in[2] = PROD_W'(u_ff[2]) * PROD_W'(v_ff[0]);
      pn_in[3] = PROD_W'(u_ff[0]) * PROD_W'(v_ff[2]);
      pn_in[4] = PROD_W'(u_ff[0]) * PROD_W'(v_ff[1]);
      pn_in[5] = PROD_W'(u_ff[1]) * PROD_W'(v_ff[0]);
      for (int i = 0; i < 3; i++) begin
         puu_in[i] = PROD_W'(u_ff[i]) * PROD_W'(u_ff[i]);
         pvv_in[i] = PROD_W'(v_ff[i]) * PROD_W'(v_ff[i]);
         puv_in[i] = PROD_W'(u_ff[i]) * PROD_W'(v_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NORM_W'(pn_ff[2*i]) - NORM_W'(pn_ff[2*i+1]);
      end
      uu_in = GRAM_W'(puu_ff[0]) + GRAM_W'(puu_ff[1]) + GRAM_W'(puu_ff[2]);
      vv_in = GRAM_W'(pvv_ff[0]) + GRAM_W'(pvv_ff[1]) + GRAM_W'(pvv_ff[2]);
      uv_in = GRAM_W'(puv_ff[0]) + GRAM_W'(puv_ff[1]) + GRAM_W'(puv_ff[2]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pa_in[i] = WP_W'(u_ff[i]) * WP_W'(uv_ff);
         pb_in[i] = WP_W'(v_ff[i]) * WP_W'(uu_ff);
         pc_in[i] = WP_W'(u_ff[i]) * WP_W'(vv_ff);
         pd_in[i] = WP_W'(v_ff[i]) * WP_W'(uv_ff);
         un_in[i] = PROJ_W'(pa_ff[i]) - PROJ_W'(pb_ff[i]);
         vn_in[i] = PROJ_W'(pc_ff[i]) - PROJ_W'(pd_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      c0_ff  <= c0_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      pn_ff  <= pn_in;
      puu_ff <= puu_in;
      pvv_ff <= pvv_in;
      puv_ff <= puv_in;
      n_ff   <= n_in;
      uu_ff  <= uu_in;
      vv_ff  <= vv_in;
      uv_ff  <= uv_in;
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      pc_ff  <= pc_in;
      pd_ff  <= pd_in;
      un_ff  <= un_in;
      vn_ff  <= vn_in;
   end

   always_comb begin
      derived.c0_x = c0_ff[0];
      derived.c0_y = c0_ff[1];
      derived.c0_z = c0_ff[2];
      derived.n_x  = n_ff[0];
      derived.n_y  = n_ff[1];
      derived.n_z  = n_ff[2];
      derived.un_x = un_ff[0];
      derived.un_y = un_ff[1];
      derived.un_z = un_ff[2];
      derived.vn_x = vn_ff[0];
      derived.vn_y = vn_ff[1];
      derived.vn_z = vn_ff[2];
      derived.uu   = uu_ff;
      derived.vv   = vv_ff;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rpi_project.sv
// ----------------------------------------------------------------------------
// Ray projection pipeline
// Forms the numerator and denominator of both edge coordinates for each ray.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_project (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire rpi_pkg::req_type      in_data,
   output logic                       in_stall,
   input  wire rpi_pkg::derived_type  derived,
   output logic                       out_valid,
   output rpi_pkg::ratio_type         out_data,
   input  wire logic                  out_stall
);
   import rpi_pkg::*;

   localparam int NS     = 6;
   localparam int MP_W   = EDGE_W + COORD_W;        // 33
   localparam int ND_W   = NORM_W + COORD_W;        // 51
   localparam int PL_W   = 62;                      // m times split projection
   localparam int DL_W   = 64;                      // split n.d times Gram term

   logic [NS-1:0] v_ff, v_in;
   logic          en;

   logic signed [EDGE_W-1:0]    wp_ff [3];
   logic signed [EDGE_W-1:0]    wp_in [3];
   logic signed [COORD_W-1:0]   d_ff [3];
   logic signed [COORD_W-1:0]   d_in [3];
   logic signed [MP_W-1:0]      mp_ff [6];
   logic signed [MP_W-1:0]      mp_in [6];
   logic signed [ND_W-1:0]      nd_ff [3];
   logic signed [ND_W-1:0]      nd_in [3];
   logic signed [CROSS_W-1:0]   m_ff [3];
   logic signed [CROSS_W-1:0]   m_in [3];
   logic signed [DEN_DOT_W-1:0] dd_ff, dd_in;
   logic signed [PL_W-1:0]      ulo_ff [3];
   logic signed [PL_W-1:0]      ulo_in [3];
   logic signed [PL_W-1:0]      uhi_ff [3];
   logic signed [PL_W-1:0]      uhi_in [3];
   logic signed [PL_W-1:0]      vlo_ff [3];
   logic signed [PL_W-1:0]      vlo_in [3];
   logic signed [PL_W-1:0]      vhi_ff [3];
   logic signed [PL_W-1:0]      vhi_in [3];
   logic signed [DL_W-1:0]      dulo_ff, dulo_in, duhi_ff, duhi_in;
   logic signed [DL_W-1:0]      dvlo_ff, dvlo_in, dvhi_ff, dvhi_in;
   logic signed [WIDE_W-1:0]    tu_ff [3];
   logic signed [WIDE_W-1:0]    tu_in [3];
   logic signed [WIDE_W-1:0]    tv_ff [3];
   logic signed [WIDE_W-1:0]    tv_in [3];
   logic signed [WIDE_W-1:0]    du5_ff, du5_in, dv5_ff, dv5_in;
   ratio_type                   res_ff, res_in;

   logic signed [COORD_W-1:0] org [3];
   logic signed [COORD_W-1:0] dir [3];
   logic signed [COORD_W-1:0] c0 [3];
   logic signed [NORM_W-1:0]  nrm [3];
   logic signed [PROJ_W-1:0]  un [3];
   logic signed [PROJ_W-1:0]  vn [3];

   // the whole module moves as one; a bubble in the last stage frees it
   assign en        = !v_ff[NS-1] || !out_stall;
   assign in_stall  = !en;
   assign out_valid = v_ff[NS-1];
   assign out_data  = res_ff;
   assign v_in      = {v_ff[NS-2:0], in_valid};

   always_comb begin
      org[0] = in_data.origin_x;
      org[1] = in_data.origin_y;
      org[2] = in_data.origin_z;
      dir[0] = in_data.direction_x;
      dir[1] = in_data.direction_y;
      dir[2] = in_data.direction_z;
      c0[0]  = derived.c0_x;
      c0[1]  = derived.c0_y;
      c0[2]  = derived.c0_z;
      nrm[0] = derived.n_x;
      nrm[1] = derived.n_y;
      nrm[2] = derived.n_z;
      un[0]  = derived.un_x;
      un[1]  = derived.un_y;
      un[2]  = derived.un_z;
      vn[0]  = derived.vn_x;
      vn[1]  = derived.vn_y;
      vn[2]  = derived.vn_z;
      for (int i = 0; i < 3; i++) begin
         wp_in[i] = EDGE_W'(org[i]) - EDGE_W'(c0[i]);
         d_in[i]  = dir[i];
      end
   end

   // cross product terms and n.d terms
   always_comb begin
      mp_in[0] = MP_W'(wp_ff[1]) * MP_W'(d_ff[2]);
      mp_in[1] = MP_W'(wp_ff[2]) * MP_W'(d_ff[1]);
      mp_in[2] = MP_W'(wp_ff[2]) * MP_W'(d_ff[0]);
      mp_in[3] = MP_W'(wp_ff[0]) * MP_W'(d_ff[2]);
      mp_in[4] = MP_W'(wp_ff[0]) * MP_W'(d_ff[1]);
      mp_in[5] = MP_W'(wp_ff[1]) * MP_W'(d_ff[0]);
      for (int i = 0; i < 3; i++) begin
         nd_in[i] = ND_W'(nrm[i]) * ND_W'(d_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_in[i] = CROSS_W'(mp_ff[2*i]) - CROSS_W'(mp_ff[2*i+1]);
      end
      dd_in = DEN_DOT_W'(nd_ff[0]) + DEN_DOT_W'(nd_ff[1]) + DEN_DOT_W'(nd_ff[2]);
   end

   // split wide operands: low part unsigned, high part signed
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ulo_in[i] = PL_W'(m_ff[i]) * PL_W'($signed({1'b0, un[i][SPLIT-1:0]}));
         uhi_in[i] = PL_W'(m_ff[i]) * PL_W'($signed(un[i][PROJ_W-1:SPLIT]));
         vlo_in[i] = PL_W'(m_ff[i]) * PL_W'($signed({1'b0, vn[i][SPLIT-1:0]}));
         vhi_in[i] = PL_W'(m_ff[i]) * PL_W'($signed(vn[i][PROJ_W-1:SPLIT]));
      end
      dulo_in = DL_W'($signed({1'b0, dd_ff[SPLIT-1:0]})) * DL_W'(derived.uu);
      duhi_in = DL_W'($signed(dd_ff[DEN_DOT_W-1:SPLIT])) * DL_W'(derived.uu);
      dvlo_in = DL_W'($signed({1'b0, dd_ff[SPLIT-1:0]})) * DL_W'(derived.vv);
      dvhi_in = DL_W'($signed(dd_ff[DEN_DOT_W-1:SPLIT])) * DL_W'(derived.vv);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tu_in[i] = (WIDE_W'(uhi_ff[i]) <<< SPLIT) + WIDE_W'(ulo_ff[i]);
         tv_in[i] = (WIDE_W'(vhi_ff[i]) <<< SPLIT) + WIDE_W'(vlo_ff[i]);
      end
      du5_in = (WIDE_W'(duhi_ff) <<< SPLIT) + WIDE_W'(dulo_ff);
      dv5_in = (WIDE_W'(dvhi_ff) <<< SPLIT) + WIDE_W'(dvlo_ff);
   end

   always_comb begin
      res_in.num_x = tu_ff[0] + tu_ff[1] + tu_ff[2];
      res_in.num_y = tv_ff[0] + tv_ff[1] + tv_ff[2];
      res_in.den_x = du5_ff;
      res_in.den_y = dv5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wp_ff   <= wp_in;
         d_ff    <= d_in;
         mp_ff   <= mp_in;
         nd_ff   <= nd_in;
         m_ff    <= m_in;
         dd_ff   <= dd_in;
         ulo_ff  <= ulo_in;
         uhi_ff  <= uhi_in;
         vlo_ff  <= vlo_in;
         vhi_ff  <= vhi_in;
         dulo_ff <= dulo_in;
         duhi_ff <= duhi_in;
         dvlo_ff <= dvlo_in;
         dvhi_ff <= dvhi_in;
         tu_ff   <= tu_in;
         tv_ff   <= tv_in;
         du5_ff  <= du5_in;
         dv5_ff  <= dv5_in;
         res_ff  <= res_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rpi_divide.sv
// ----------------------------------------------------------------------------
// Pixel division pipeline
// Range-checks both edge ratios and forms the pixel quotients bit by bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_divide #(
   parameter int MAX_PANEL_DIM = rpi_pkg::MAX_PANEL_DIM_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire rpi_pkg::ratio_type          in_data,
   output logic                             in_stall,
   input  wire logic [rpi_pkg::DIM_W-1:0]   panel_width,
   input  wire logic [rpi_pkg::DIM_W-1:0]   panel_height,
   output logic                             out_valid,
   output rpi_pkg::rsp_type                 out_data,
   input  wire logic                        out_stall
);
   import rpi_pkg::*;

   localparam int QW     = $clog2(MAX_PANEL_DIM + 1);
   localparam int TW     = WIDE_W + QW;
   localparam int HALF   = WIDE_W / 2;
   localparam int HI_W   = WIDE_W - HALF;
   localparam int NS     = QW + 4;

   logic [NS-1:0] v_ff, v_in;
   logic          en;

   logic [QW-1:0]            dimc [2];
   logic signed [WIDE_W-1:0] num0 [2];
   logic signed [WIDE_W-1:0] den0 [2];

   logic signed [WIDE_W-1:0] num1_ff [2];
   logic signed [WIDE_W-1:0] num1_in [2];
   logic signed [WIDE_W-1:0] den1_ff [2];
   logic signed [WIDE_W-1:0] den1_in [2];
   logic                     ok2_ff [2];
   logic                     ok2_in [2];
   logic [HALF+QW-1:0]       plo2_ff [2];
   logic [HALF+QW-1:0]       plo2_in [2];
   logic [HI_W+QW-1:0]       phi2_ff [2];
   logic [HI_W+QW-1:0]       phi2_in [2];
   logic [WIDE_W-1:0]        den2_ff [2];
   logic [WIDE_W-1:0]        den2_in [2];

   // division stage arrays: index 0 holds the formed dividend
   logic [TW-1:0]     rem_ff [QW+1][2];
   logic [TW-1:0]     rem_in [QW+1][2];
   logic [QW-1:0]     q_ff   [QW+1][2];
   logic [QW-1:0]     q_in   [QW+1][2];
   logic [WIDE_W-1:0] dv_ff  [QW+1][2];
   logic [WIDE_W-1:0] dv_in  [QW+1][2];
   logic              ok_ff  [QW+1][2];
   logic              ok_in  [QW+1][2];
   logic [TW-1:0]     sub [QW][2];

   rsp_type res_ff, res_in;

   assign en        = !v_ff[NS-1] || !out_stall;
   assign in_stall  = !en;
   assign out_valid = v_ff[NS-1];
   assign out_data  = res_ff;
   assign v_in      = {v_ff[NS-2:0], in_valid};

   always_comb begin
      num0[0] = in_data.num_x;
      den0[0] = in_data.den_x;
      num0[1] = in_data.num_y;
      den0[1] = in_data.den_y;
      dimc[0] = (32'(panel_width) > 32'(MAX_PANEL_DIM)) ? QW'(MAX_PANEL_DIM)
                                                         : QW'(panel_width);
      dimc[1] = (32'(panel_height) > 32'(MAX_PANEL_DIM)) ? QW'(MAX_PANEL_DIM)
                                                          : QW'(panel_height);
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         // make the denominator non-negative
         num1_in[a] = den0[a][WIDE_W-1] ? -num0[a] : num0[a];
         den1_in[a] = den0[a][WIDE_W-1] ? -den0[a] : den0[a];

         ok2_in[a]  = (den1_ff[a] != '0) && !num1_ff[a][WIDE_W-1] &&
                      (num1_ff[a] <= den1_ff[a]);
         plo2_in[a] = (HALF+QW)'(num1_ff[a][HALF-1:0]) * (HALF+QW)'(dimc[a]);
         phi2_in[a] = (HI_W+QW)'(num1_ff[a][WIDE_W-1:HALF]) * (HI_W+QW)'(dimc[a]);
         den2_in[a] = den1_ff[a];

         rem_in[0][a] = (TW'(phi2_ff[a]) << HALF) + TW'(plo2_ff[a]);
         q_in[0][a]   = '0;
         dv_in[0][a]  = den2_ff[a];
         ok_in[0][a]  = ok2_ff[a];
      end

      // one quotient bit per stage, most significant first
      for (int j = 0; j < QW; j++) begin
         for (int a = 0; a < 2; a++) begin
            sub[j][a] = TW'(dv_ff[j][a]) << (QW - 1 - j);
            if (rem_ff[j][a] >= sub[j][a]) begin
               rem_in[j+1][a] = rem_ff[j][a] - sub[j][a];
               q_in[j+1][a]   = q_ff[j][a] | (QW'(1) << (QW - 1 - j));
            end else begin
               rem_in[j+1][a] = rem_ff[j][a];
               q_in[j+1][a]   = q_ff[j][a];
            end
            dv_in[j+1][a] = dv_ff[j][a];
            ok_in[j+1][a] = ok_ff[j][a];
         end
      end
   end

   always_comb begin
      res_in.hit = ok_ff[QW][0] && ok_ff[QW][1];
      if (res_in.hit) begin
         res_in.pixel_x = $signed(PIX_W'(q_ff[QW][0]));
         res_in.pixel_y = $signed(PIX_W'(q_ff[QW][1]));
      end else begin
         res_in.pixel_x = MISS_PIXEL;
         res_in.pixel_y = MISS_PIXEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff <= num1_in;
         den1_ff <= den1_in;
         ok2_ff  <= ok2_in;
         plo2_ff <= plo2_in;
         phi2_ff <= phi2_in;
         den2_ff <= den2_in;
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         dv_ff   <= dv_in;
         ok_ff   <= ok_in;
         res_ff  <= res_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ray_panel_intersection_core.sv
// ----------------------------------------------------------------------------
// Ray/panel intersection core
// Pipeline: 6 projection stages, 3 range/scale stages, one divider stage per
//   quotient bit and one output register. Throughput: one ray per cycle
//   unless rsp_stall holds the pipeline or the panel terms settle.
// Reset: clears all pipeline valids, loads the register reset values and
//   holds req_stall, as after any register write, while the corner-derived
//   terms settle.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_panel_intersection_core #(
   parameter int MAX_PANEL_DIM = rpi_pkg::MAX_PANEL_DIM_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire rpi_pkg::req_type               req_data,
   output logic                                req_stall,
   output logic                                rsp_valid,
   output rpi_pkg::rsp_type                    rsp_data,
   input  wire logic                           rsp_stall,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [rpi_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rpi_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rpi_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import rpi_pkg::*;

   // Configuration registers
   logic [CORNER_W-1:0] corner_origin_ff, corner_origin_in;
   logic [CORNER_W-1:0] corner_u_end_ff, corner_u_end_in;
   logic [CORNER_W-1:0] corner_v_end_ff, corner_v_end_in;
   logic [DIM_W-1:0]    panel_width_ff, panel_width_in;
   logic [DIM_W-1:0]    panel_height_ff, panel_height_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   logic          csr_write;
   reg_index_type csr_index;

   derived_type derived;
   logic        proj_in_valid, proj_in_stall;
   logic        proj_out_valid, div_in_stall;
   ratio_type   ratio;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   // Register writes: one 64-bit register every 8 bytes
   always_comb begin
      corner_origin_in = corner_origin_ff;
      corner_u_end_in  = corner_u_end_ff;
      corner_v_end_in  = corner_v_end_ff;
      panel_width_in   = panel_width_ff;
      panel_height_in  = panel_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CORNER_ORIGIN: corner_origin_in = csr_pwdata[CORNER_W-1:0];
            REG_CORNER_U_END:  corner_u_end_in  = csr_pwdata[CORNER_W-1:0];
            REG_CORNER_V_END:  corner_v_end_in  = csr_pwdata[CORNER_W-1:0];
            REG_PANEL_WIDTH:   panel_width_in   = csr_pwdata[DIM_W-1:0];
            REG_PANEL_HEIGHT:  panel_height_in  = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CORNER_ORIGIN: csr_prdata = CSR_DATA_W'(corner_origin_ff);
         REG_CORNER_U_END:  csr_prdata = CSR_DATA_W'(corner_u_end_ff);
         REG_CORNER_V_END:  csr_prdata = CSR_DATA_W'(corner_v_end_ff);
         REG_PANEL_WIDTH:   csr_prdata = CSR_DATA_W'(panel_width_ff);
         REG_PANEL_HEIGHT:  csr_prdata = CSR_DATA_W'(panel_height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Settle counter: reload on any write, count down to zero
   always_comb begin
      if (csr_write) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_origin_ff <= CORNER_ORIGIN_RST;
         corner_u_end_ff  <= CORNER_U_END_RST;
         corner_v_end_ff  <= CORNER_V_END_RST;
         panel_width_ff   <= PANEL_DIM_RST;
         panel_height_ff  <= PANEL_DIM_RST;
         settle_ff        <= SETTLE_CYCLES;
      end else begin
         corner_origin_ff <= corner_origin_in;
         corner_u_end_ff  <= corner_u_end_in;
         corner_v_end_ff  <= corner_v_end_in;
         panel_width_ff   <= panel_width_in;
         panel_height_ff  <= panel_height_in;
         settle_ff        <= settle_in;
      end
   end

   // Hold off new transactions until the derived panel terms are current
   assign proj_in_valid = req_valid && (settle_ff == '0);
   assign req_stall     = proj_in_stall || (settle_ff != '0);

   rpi_setup u_setup (
      .clock         (clock),
      .corner_origin (corner_origin_ff),
      .corner_u_end  (corner_u_end_ff),
      .corner_v_end  (corner_v_end_ff),
      .derived       (derived)
   );

   // Ray-dependent products down to the wide numerators and denominators
   rpi_project u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_in_valid),
      .in_data   (req_data),
      .in_stall  (proj_in_stall),
      .derived   (derived),
      .out_valid (proj_out_valid),
      .out_data  (ratio),
      .out_stall (div_in_stall)
   );

   // Range check and quotient; its last stage is the result register
   rpi_divide #(
      .MAX_PANEL_DIM (MAX_PANEL_DIM)
   ) u_divide (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (proj_out_valid),
      .in_data      (ratio),
      .in_stall     (div_in_stall),
      .panel_width  (panel_width_ff),
      .panel_height (panel_height_ff),
      .out_valid    (rsp_valid),
      .out_data     (rsp_data),
      .out_stall    (rsp_stall)
   );

   // No transaction enters while the derived terms are settling
   assert property (@(posedge clock) disable iff (reset)
      (settle_ff != '0) |-> req_stall)
      else $error("transaction accepted while panel terms settle");

   // A register write blocks input on the following cycle
   assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("input not held after register write");

   // A miss always carries the miss marker on both axes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.pixel_x == MISS_PIXEL && rsp_data.pixel_y == MISS_PIXEL))
      else $error("miss without miss pixels");

   // A hit never reports the miss marker on either axis
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |->
         (rsp_data.pixel_x != MISS_PIXEL && rsp_data.pixel_y != MISS_PIXEL))
      else $error("hit with miss pixel value");

endmodule

`default_nettype wire

FILE: verif/tb_ray_panel_intersection_core.sv
// ----------------------------------------------------------------------------
// Ray/panel intersection core testbench
// Drives rays over the valid/stall request channel and checks the response
// stream in order against hand-typed results or pixel predictions from the
// panel registers in exact wide arithmetic. Registers are rewritten between
// traffic phases over APB, covering degenerate panels and dimension extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ray_panel_intersection_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rpi_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      req_type ray;
      bit      known;    // result typed in by hand
      rsp_type result;
   } stim_row_type;

   localparam int  PIPE_DRAIN  = 40;
   localparam int  LONG_HOLD   = 400;
   localparam longint CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_data = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  rsp_stall = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow copy of the panel registers
   logic [CORNER_W-1:0] panel_corner [3];
   logic [DIM_W-1:0]    panel_w;
   logic [DIM_W-1:0]    panel_h;

   rsp_type pixel_queue [$];
   bit      failed = 1'b0;
   bit      quiet = 1'b0;      // no idling on either side
   bit      hold_request = 1'b0;
   longint  cycle_count = 0;

   ray_panel_intersection_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Run guard: abandon the run once the cycle count passes CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[ray_panel_intersection_core] ERROR");
         $finish;
      end
   end

   // Unpack one signed Q7.8 word of a packed corner (0 = x, 1 = y, 2 = z).
   function automatic longint corner_axis(logic [CORNER_W-1:0] c, int axis);
      logic signed [COORD_W-1:0] word;
      word = c[(2-axis)*16 +: 16];
      return longint'(word);
   endfunction

   // Scale num/den into a pixel index, or -1 when the ratio leaves [0,1].
   function automatic int ratio_to_pixel(wide_type num, wide_type den,
                                         logic [DIM_W-1:0] dim);
      wide_type span;
      if (den == 0) return -1;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num < 0 || num > den) return -1;
      span = (dim > 1024) ? wide_type'(1024) : wide_type'(dim);
      return int'((num * span) / den);
   endfunction

   // Work out the hit and pixel pair for one ray against the current panel.
   function automatic rsp_type predict_pixel(req_type r);
      longint u[3], v[3], wp[3], d[3], n[3], m[3], un[3], vn[3];
      longint dd, uu, vv, uv;
      wide_type nu, nv;
      int     px, py;
      rsp_type res;
      wp[0] = longint'(r.origin_x);
      wp[1] = longint'(r.origin_y);
      wp[2] = longint'(r.origin_z);
      d[0]  = longint'(r.direction_x);
      d[1]  = longint'(r.direction_y);
      d[2]  = longint'(r.direction_z);
      for (int i = 0; i < 3; i++) begin
         u[i]  = corner_axis(panel_corner[1], i) - corner_axis(panel_corner[0], i);
         v[i]  = corner_axis(panel_corner[2], i) - corner_axis(panel_corner[0], i);
         wp[i] = wp[i] - corner_axis(panel_corner[0], i);
      end
      n[0] = u[1]*v[2] - u[2]*v[1];
      n[1] = u[2]*v[0] - u[0]*v[2];
      n[2] = u[0]*v[1] - u[1]*v[0];
      m[0] = wp[1]*d[2] - wp[2]*d[1];
      m[1] = wp[2]*d[0] - wp[0]*d[2];
      m[2] = wp[0]*d[1] - wp[1]*d[0];
      dd = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
      uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
      vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
      nu = 0;
      nv = 0;
      for (int i = 0; i < 3; i++) begin
         un[i] = u[i]*uv - v[i]*uu;
         vn[i] = u[i]*vv - v[i]*uv;
         nu = nu + wide_type'(m[i]) * wide_type'(un[i]);
         nv = nv + wide_type'(m[i]) * wide_type'(vn[i]);
      end
      px = ratio_to_pixel(nu, wide_type'(dd) * wide_type'(uu), panel_w);
      py = ratio_to_pixel(nv, wide_type'(dd) * wide_type'(vv), panel_h);
      if (dd == 0 || px < 0 || py < 0) begin
         res.hit     = 1'b0;
         res.pixel_x = MISS_PIXEL;
         res.pixel_y = MISS_PIXEL;
      end else begin
         res.hit     = 1'b1;
         res.pixel_x = PIX_W'(px);
         res.pixel_y = PIX_W'(py);
      end
      return res;
   endfunction

   function automatic req_type make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
      req_type r;
      r.origin_x    = COORD_W'(ox);
      r.origin_y    = COORD_W'(oy);
      r.origin_z    = COORD_W'(oz);
      r.direction_x = COORD_W'(dx);
      r.direction_y = COORD_W'(dy);
      r.direction_z = COORD_W'(dz);
      return r;
   endfunction

   function automatic logic [CORNER_W-1:0] pack_corner(int x, int y, int z);
      return {16'(x), 16'(y), 16'(z)};
   endfunction

   function automatic rsp_type pixel_pair(bit h, int px, int py);
      rsp_type r;
      r.hit     = h;
      r.pixel_x = PIX_W'(px);
      r.pixel_y = PIX_W'(py);
      return r;
   endfunction

   function automatic int clamp_coord(int x);
      return (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
   endfunction

   // APB write: setup cycle, access cycle, then release the bus.
   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel   = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr  = CSR_ADDR_W'(8 * int'(idx));
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (idx)
         REG_CORNER_ORIGIN: panel_corner[0] = value[CORNER_W-1:0];
         REG_CORNER_U_END:  panel_corner[1] = value[CORNER_W-1:0];
         REG_CORNER_V_END:  panel_corner[2] = value[CORNER_W-1:0];
         REG_PANEL_WIDTH:   panel_w = value[DIM_W-1:0];
         default:           panel_h = value[DIM_W-1:0];
      endcase
   endtask

   task automatic write_panel(logic [CORNER_W-1:0] c0, logic [CORNER_W-1:0] c1,
                              logic [CORNER_W-1:0] c3, int w, int h);
      write_reg(REG_CORNER_ORIGIN, CSR_DATA_W'(c0));
      write_reg(REG_CORNER_U_END,  CSR_DATA_W'(c1));
      write_reg(REG_CORNER_V_END,  CSR_DATA_W'(c3));
      write_reg(REG_PANEL_WIDTH,   CSR_DATA_W'(w));
      write_reg(REG_PANEL_HEIGHT,  CSR_DATA_W'(h));
   endtask

   // Offer one ray after an idle gap; hold it until the core takes it.
   task automatic send_ray(req_type r, bit known, rsp_type result);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      pixel_queue.push_back(known ? result : predict_pixel(r));
   endtask

   // Drop valid and wait for the pipeline to empty before touching registers.
   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   // Random corner near the origin so that aimed rays stay within Q7.8 range.
   function automatic logic [CORNER_W-1:0] near_corner();
      return pack_corner($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                         $urandom_range(0, 4096) - 2048);
   endfunction

   // Random ray: mostly aimed at (or just past) the panel, the rest noise.
   function automatic req_type random_ray();
      int ox, oy, oz, a, b, t;
      int tgt[3];
      if ($urandom_range(0, 9) < 2)
         return req_type'({$urandom, $urandom, $urandom});
      ox = $urandom_range(0, 8192) - 4096;
      oy = $urandom_range(0, 8192) - 4096;
      oz = $urandom_range(0, 8192) - 4096;
      a  = $urandom_range(0, 300) - 22;
      b  = $urandom_range(0, 300) - 22;
      for (int i = 0; i < 3; i++) begin
         t = int'(corner_axis(panel_corner[0], i));
         tgt[i] = t + (a * (int'(corner_axis(panel_corner[1], i)) - t)
                     + b * (int'(corner_axis(panel_corner[2], i)) - t)) / 256;
      end
      return make_ray(ox, oy, oz, clamp_coord(tgt[0] - ox), clamp_coord(tgt[1] - oy),
                      clamp_coord(tgt[2] - oz));
   endfunction

   // Response checker: compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            $display("%0t: unexpected result hit=%0d x=%0d y=%0d", $time,
                     rsp_data.hit, rsp_data.pixel_x, rsp_data.pixel_y);
            failed = 1'b1;
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp_data.hit);
               failed = 1'b1;
            end
            if (rsp_data.pixel_x !== want.pixel_x) begin
               $display("%0t: pixel_x expected %0d actual %0d", $time,
                        want.pixel_x, rsp_data.pixel_x);
               failed = 1'b1;
            end
            if (rsp_data.pixel_y !== want.pixel_y) begin
               $display("%0t: pixel_y expected %0d actual %0d", $time,
                        want.pixel_y, rsp_data.pixel_y);
               failed = 1'b1;
            end
         end
      end
   end

   // Result receiver: random stall before each transaction, one long hold on request.
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 15);
         if (hold_request) begin
            n = LONG_HOLD;
            hold_request = 1'b0;
         end
         repeat (n) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      stim_row_type rows [$];
      int w, h;
      logic [CORNER_W-1:0] c0, c1, c3;

      panel_corner[0] = CORNER_ORIGIN_RST;
      panel_corner[1] = CORNER_U_END_RST;
      panel_corner[2] = CORNER_V_END_RST;
      panel_w = PANEL_DIM_RST;
      panel_h = PANEL_DIM_RST;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Reset values: random rays against the reset panel.
      for (int k = 0; k < 60; k++) send_ray(random_ray(), 1'b0, '0);
      drain();

      // Unit panel in the z = 0 plane, 512 by 256 pixels.
      write_panel(pack_corner(0, 0, 0), pack_corner(256, 0, 0), pack_corner(0, 256, 0),
                  512, 256);
      // centre, both boundary corners, hit behind the origin
      rows.push_back('{make_ray(128, 128, 256, 0, 0, -256), 1, pixel_pair(1, 256, 128)});
      rows.push_back('{make_ray(0, 0, 256, 0, 0, -256), 1, pixel_pair(1, 0, 0)});
      rows.push_back('{make_ray(256, 256, 256, 0, 0, -256), 1, pixel_pair(1, 512, 256)});
      rows.push_back('{make_ray(128, 128, -256, 0, 0, -256), 1, pixel_pair(1, 256, 128)});
      // parallel ray, zero direction, outside either edge
      rows.push_back('{make_ray(128, 128, 256, 256, 0, 0), 1, pixel_pair(0, -99, -99)});
      rows.push_back('{make_ray(128, 128, 256, 0, 0, 0), 1, pixel_pair(0, -99, -99)});
      rows.push_back('{make_ray(512, 0, 256, 0, 0, -256), 1, pixel_pair(0, -99, -99)});
      rows.push_back('{make_ray(-1, 0, 256, 0, 0, -256), 1, pixel_pair(0, -99, -99)});
      rows.push_back('{make_ray(0, 257, 256, 0, 0, -256), 1, pixel_pair(0, -99, -99)});
      // field extremes and oblique rays
      rows.push_back('{make_ray(32767, 32767, 32767, -32768, -32768, -32768), 0, '0});
      rows.push_back('{make_ray(-32768, -32768, -32768, 32767, 32767, 32767), 0, '0});
      rows.push_back('{make_ray(-32768, 32767, -32768, 32767, -32768, 32767), 0, '0});
      rows.push_back('{make_ray(0, 0, 32767, 64, 64, -32768), 0, '0});
      rows.push_back('{make_ray(200, 50, 1, 3, -7, -1), 0, '0});
      rows.push_back('{make_ray(255, 255, 256, 0, 0, -256), 0, '0});
      rows.push_back('{make_ray(-1, -1, -1, 0, 0, 1), 0, '0});
      foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].result);
      drain();

      // Random phases, each under its own panel setting.
      for (int phase = 0; phase < 8; phase++) begin
         c0 = near_corner();
         c1 = near_corner();
         c3 = near_corner();
         case (phase)
            0: begin w = 1; h = 1; end
            1: begin w = 1024; h = 1024; end
            2: begin w = 2047; h = 0; c3 = c0; end        // oversized, zero, null edge
            3: begin w = 0; h = 1500; c1 = c0 + (c3 - c0); end   // parallel edges
            4: begin
               w = $urandom_range(1, 1024); h = $urandom_range(1, 1024);
               c0 = CORNER_W'({$urandom, $urandom});
               c1 = CORNER_W'({$urandom, $urandom});
               c3 = CORNER_W'({$urandom, $urandom});
            end
            5: begin w = 640; h = 480; c0 = '1; c1 = '0; end
            default: begin w = $urandom_range(1, 1024); h = $urandom_range(1, 1024); end
         endcase
         write_panel(c0, c1, c3, w, h);
         quiet = (phase == 6);
         // Long receiver hold while the sender keeps offering rays.
         if (phase == 1) begin
            quiet = 1'b1;
            hold_request = 1'b1;
         end
         for (int k = 0; k < 95; k++) send_ray(random_ray(), 1'b0, '0);
         quiet = 1'b0;
         drain();
      end

      if (!failed)
         $display("[ray_panel_intersection_core] OK");
      else
         $display("[ray_panel_intersection_core] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
